### hw/rtl/quadrature_position_tracker_core_macros.svh
// assertion macros for the quadrature position tracker
// used by quadrature_position_tracker_core; define NO_ASSERTIONS to drop them
`ifndef QUADRATURE_POSITION_TRACKER_CORE_MACROS_SVH
`define QUADRATURE_POSITION_TRACKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define QPT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qpt same-cycle check failed");

`define QPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qpt next-cycle check failed");

`else

`define QPT_ASSERT_SAME(label, clk, rst, ante, cons)

`define QPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/qpt_pkg.sv
// shared types, codes and step table for the quadrature position tracker
// no dependencies
package qpt_pkg;

   localparam logic [2:0] KIND_SAMPLE     = 3'd0;
   localparam logic [2:0] KIND_SET        = 3'd1;
   localparam logic [2:0] KIND_READ_CLEAR = 3'd2;
   localparam logic [2:0] KIND_DELTA      = 3'd3;
   localparam logic [2:0] KIND_DIRECTION  = 3'd4;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   localparam logic [1:0] PHASE_RESET = 2'd3;

   // step per {old phase, new phase}
   localparam logic signed [1:0] STEP_TABLE [16] = '{
      2'sd0,  -2'sd1, 2'sd1,  2'sd0,
      2'sd1,  2'sd0,  2'sd0,  -2'sd1,
      -2'sd1, 2'sd0,  2'sd0,  2'sd1,
      2'sd0,  2'sd1,  -2'sd1, 2'sd0
   };

   typedef struct packed {
      logic [2:0]         kind;
      logic               phase_a;
      logic               phase_b;
      logic [31:0]        now_ms;
      logic signed [31:0] new_position;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] read_value;
      logic [1:0]         direction;
      logic [31:0]        edge_interval_ms;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  last_phase_state;
      logic [31:0] position_count;
      logic [31:0] direction_snapshot;
      logic [31:0] delta_snapshot;
      logic [31:0] last_edge_time;
      logic [31:0] prior_edge_time;
   } track_state_type;

endpackage

### hw/rtl/quadrature_position_tracker_core.sv
// an accepted word is held in the request stage, and its result is registered in the result stage
// throughput: one word per cycle while rsp_stall is low; request and result sides part at two registers
// the request stage keeps accepting while a finished result waits, until it fills
// reset (synchronous, active high) empties both stages, phase state to 3, counts to 0
// depends on qpt_pkg, qpt_update and quadrature_position_tracker_core_macros.svh
`include "quadrature_position_tracker_core_macros.svh"
module quadrature_position_tracker_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  qpt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output qpt_pkg::rsp_word_type rsp_word
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   qpt_pkg::req_word_type    in_word_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   qpt_pkg::rsp_word_type    out_word_ff;
   qpt_pkg::track_state_type state_ff;
   qpt_pkg::track_state_type state_in;
   qpt_pkg::track_state_type state_calc;
   qpt_pkg::rsp_word_type    rsp_calc;
   logic                     out_advance;
   logic                     fire;
   logic                     req_take;
   logic                     fire_clear;
   logic                     fire_dir;

   assign out_advance = !out_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && out_advance;
   assign req_stall   = in_valid_ff && !out_advance;
   assign req_take    = req_valid && !req_stall;
   assign fire_clear  = fire && (in_word_ff.kind == qpt_pkg::KIND_READ_CLEAR);
   assign fire_dir    = fire && (in_word_ff.kind == qpt_pkg::KIND_DIRECTION);

   qpt_update u_update (
      .word       (in_word_ff),
      .state_cur  (state_ff),
      .state_next (state_calc),
      .rsp        (rsp_calc)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
      end
      if (fire) begin
         in_valid_in = 1'b0;
         state_in    = state_calc;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         state_ff.last_phase_state   <= qpt_pkg::PHASE_RESET;
         state_ff.position_count     <= '0;
         state_ff.direction_snapshot <= '0;
         state_ff.delta_snapshot     <= '0;
         state_ff.last_edge_time     <= '0;
         state_ff.prior_edge_time    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (fire) begin
         out_word_ff <= rsp_calc;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // state moves only when a word passes the update stage
   `QPT_ASSERT_NEXT(a_state_hold, clock, reset, !fire, $stable(state_ff))
   // blocked request stage keeps its word
   `QPT_ASSERT_NEXT(a_in_hold, clock, reset, req_stall, in_valid_ff && $stable(in_word_ff))
   `QPT_ASSERT_NEXT(a_clear_zero, clock, reset, fire_clear, state_ff.position_count == '0)
   `QPT_ASSERT_NEXT(a_dir_snap, clock, reset, fire_dir, state_ff.direction_snapshot == state_ff.position_count)

endmodule

### hw/rtl/qpt_update.sv
// next tracker state and result word for one request word
// depends on qpt_pkg
module qpt_update (
   input  qpt_pkg::req_word_type    word,
   input  qpt_pkg::track_state_type state_cur,
   output qpt_pkg::track_state_type state_next,
   output qpt_pkg::rsp_word_type    rsp
);

   logic [1:0]         phase_now;
   logic [3:0]         step_index;
   logic signed [1:0]  step;
   logic [31:0]        step_ext;
   logic [31:0]        delta_diff;
   logic [31:0]        dir_diff;
   logic [31:0]        read_value;
   logic [1:0]         direction;

   assign phase_now  = {word.phase_a, word.phase_b};
   assign step_index = {state_cur.last_phase_state, phase_now};
   assign step       = qpt_pkg::STEP_TABLE[step_index];
   assign step_ext   = {{30{step[1]}}, step};
   assign delta_diff = state_cur.position_count - state_cur.delta_snapshot;
   assign dir_diff   = state_cur.direction_snapshot - state_cur.position_count;

   always_comb begin
      state_next = state_cur;
      read_value = '0;
      direction  = qpt_pkg::DIR_NONE;
      case (word.kind)
         qpt_pkg::KIND_SAMPLE: begin
            if (phase_now != state_cur.last_phase_state) begin
               state_next.position_count   = state_cur.position_count + step_ext;
               state_next.prior_edge_time  = state_cur.last_edge_time;
               state_next.last_edge_time   = word.now_ms;
               state_next.last_phase_state = phase_now;
            end
         end
         qpt_pkg::KIND_SET: begin
            state_next.position_count     = word.new_position;
            state_next.direction_snapshot = word.new_position;
            state_next.delta_snapshot     = word.new_position;
         end
         qpt_pkg::KIND_READ_CLEAR: begin
            read_value                = state_cur.position_count;
            state_next.position_count = '0;
         end
         qpt_pkg::KIND_DELTA: begin
            read_value                = delta_diff;
            state_next.delta_snapshot = state_cur.position_count;
         end
         qpt_pkg::KIND_DIRECTION: begin
            if (dir_diff == '0) begin
               direction = qpt_pkg::DIR_NONE;
            end else if (dir_diff[31]) begin
               direction = qpt_pkg::DIR_CW;
            end else begin
               direction = qpt_pkg::DIR_CCW;
            end
            state_next.direction_snapshot = state_cur.position_count;
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

   always_comb begin
      rsp.position         = state_next.position_count;
      rsp.read_value       = read_value;
      rsp.direction        = direction;
      rsp.edge_interval_ms = state_next.last_edge_time - state_next.prior_edge_time;
   end

endmodule

### dv/tb_quadrature_position_tracker_core.sv
`timescale 1ns / 1ps
// testbench for quadrature_position_tracker_core: directed and random request words,
// with a local copy of the tracker state predicting every result word
// depends on qpt_pkg and the rtl of the core
module tb_quadrature_position_tracker_core;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   qpt_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   qpt_pkg::rsp_word_type rsp_word;

   // local tracker state
   logic [1:0]  trk_phase = qpt_pkg::PHASE_RESET;
   logic [31:0] trk_position = '0;
   logic [31:0] trk_dir_mark = '0;
   logic [31:0] trk_delta_mark = '0;
   logic [31:0] trk_edge_new = '0;
   logic [31:0] trk_edge_old = '0;

   qpt_pkg::rsp_word_type tracker_reports [$];
   int unsigned    errors = 0;
   int unsigned    cycles = 0;
   int unsigned    burst_left = 0;
   int unsigned    hold_cycles = 0;
   int unsigned    mode_left = 0;
   bit             no_gaps = 1'b0;
   bit             rsp_quiet = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;

   quadrature_position_tracker_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("status: fail");
         $finish;
      end
   end

   // position along the gray sequence 00 -> 10 -> 11 -> 01
   function automatic logic [1:0] phase_ordinal(input logic [1:0] ph);
      case (ph)
         2'b00: return 2'd0;
         2'b10: return 2'd1;
         2'b11: return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] ordinal_phase(input logic [1:0] ord);
      case (ord)
         2'd0: return 2'b00;
         2'd1: return 2'b10;
         2'd2: return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   function automatic qpt_pkg::rsp_word_type advance_tracker(input qpt_pkg::req_word_type w);
      qpt_pkg::rsp_word_type r;
      logic [1:0]   cur;
      logic [1:0]   turn;
      logic [31:0]  diff;
      cur = {w.phase_a, w.phase_b};
      r.read_value = '0;
      r.direction = qpt_pkg::DIR_NONE;
      case (w.kind)
         qpt_pkg::KIND_SAMPLE: begin
            if (cur != trk_phase) begin
               turn = phase_ordinal(cur) - phase_ordinal(trk_phase);
               if (turn == 2'd1) trk_position = trk_position + 32'd1;
               else if (turn == 2'd3) trk_position = trk_position - 32'd1;
               trk_edge_old = trk_edge_new;
               trk_edge_new = w.now_ms;
               trk_phase = cur;
            end
         end
         qpt_pkg::KIND_SET: begin
            trk_position = w.new_position;
            trk_dir_mark = w.new_position;
            trk_delta_mark = w.new_position;
         end
         qpt_pkg::KIND_READ_CLEAR: begin
            r.read_value = trk_position;
            trk_position = '0;
         end
         qpt_pkg::KIND_DELTA: begin
            r.read_value = trk_position - trk_delta_mark;
            trk_delta_mark = trk_position;
         end
         qpt_pkg::KIND_DIRECTION: begin
            diff = trk_dir_mark - trk_position;
            if (diff == '0) r.direction = qpt_pkg::DIR_NONE;
            else if (diff[31]) r.direction = qpt_pkg::DIR_CW;
            else r.direction = qpt_pkg::DIR_CCW;
            trk_dir_mark = trk_position;
         end
         default: begin
         end
      endcase
      r.position = trk_position;
      r.edge_interval_ms = trk_edge_new - trk_edge_old;
      return r;
   endfunction

   function automatic qpt_pkg::req_word_type rand_word(input logic [2:0] kind);
      qpt_pkg::req_word_type w;
      w.kind = kind;
      w.phase_a = 1'($urandom_range(0, 1));
      w.phase_b = 1'($urandom_range(0, 1));
      w.now_ms = $urandom;
      w.new_position = $urandom;
      return w;
   endfunction

   task automatic send_word(input qpt_pkg::req_word_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_word = w;
      do @(posedge clock); while (req_stall);
      tracker_reports.push_back(advance_tracker(w));
   endtask

   task automatic send_sample(input logic [1:0] ph, input logic [31:0] stamp);
      qpt_pkg::req_word_type w;
      w = rand_word(qpt_pkg::KIND_SAMPLE);
      {w.phase_a, w.phase_b} = ph;
      w.now_ms = stamp;
      send_word(w);
   endtask

   task automatic send_set(input logic [31:0] value);
      qpt_pkg::req_word_type w;
      w = rand_word(qpt_pkg::KIND_SET);
      w.new_position = value;
      send_word(w);
   endtask

   task automatic drain_reports();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      qpt_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tracker_reports.size() == 0) begin
            $display("%0t unexpected result word: expected none actual %h", $time, rsp_word);
            errors++;
         end else begin
            want = tracker_reports.pop_front();
            check_field("position", want.position, rsp_word.position);
            check_field("read_value", want.read_value, rsp_word.read_value);
            check_field("direction", 32'(want.direction), 32'(rsp_word.direction));
            check_field("edge_interval_ms", want.edge_interval_ms, rsp_word.edge_interval_ms);
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_cycles != 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else if (rsp_quiet) begin
         rsp_stall = 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE: rsp_stall = 1'b0;
            STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
            default: rsp_stall = ((mode_left % 5) < 2);
         endcase
      end
   end

   task automatic test_phase_steps();
      send_sample(2'b11, 32'd5);
      send_sample(2'b01, 32'd0);
      send_sample(2'b00, 32'hFFFF_FFFF);
      send_sample(2'b10, 32'd3);
      send_sample(2'b11, 32'd10);
      send_sample(2'b10, 32'd11);
      send_sample(2'b00, 32'd13);
      // double changes count nothing but still move the edge times
      send_sample(2'b11, 32'd20);
      send_sample(2'b00, 32'd21);
      drain_reports();
   endtask

   task automatic test_position_wrap();
      send_set(32'h7FFF_FFFF);
      send_sample(2'b10, 32'd30);
      send_set(32'h8000_0000);
      send_sample(2'b00, 32'd31);
      send_set(32'hFFFF_FFFF);
      send_sample(2'b10, 32'd32);
      drain_reports();
   endtask

   task automatic test_read_kinds();
      send_set(32'd100);
      send_sample(2'b11, 32'd40);
      send_word(rand_word(qpt_pkg::KIND_DIRECTION));
      send_sample(2'b10, 32'd41);
      send_sample(2'b00, 32'd42);
      send_word(rand_word(qpt_pkg::KIND_DIRECTION));
      send_word(rand_word(qpt_pkg::KIND_DIRECTION));
      send_word(rand_word(qpt_pkg::KIND_DELTA));
      send_word(rand_word(qpt_pkg::KIND_DELTA));
      send_word(rand_word(qpt_pkg::KIND_READ_CLEAR));
      send_word(rand_word(qpt_pkg::KIND_READ_CLEAR));
      drain_reports();
   endtask

   task automatic test_unused_kinds();
      send_word(rand_word(3'(qpt_pkg::KIND_DIRECTION + 3'd1)));
      send_word(rand_word(3'(qpt_pkg::KIND_DIRECTION + 3'd2)));
      send_word(rand_word(3'(qpt_pkg::KIND_DIRECTION + 3'd3)));
      drain_reports();
   endtask

   task automatic test_random_rotation(input int unsigned count);
      int unsigned  pick;
      int unsigned  choice;
      logic [31:0]  stamp;
      logic [1:0]   walk_ord;
      logic [1:0]   walk_dir;
      qpt_pkg::req_word_type w;
      stamp = $urandom;
      walk_ord = phase_ordinal(trk_phase);
      walk_dir = 2'd1;
      for (int i = 0; i < count; i++) begin
         no_gaps = (i < 100);
         rsp_quiet = (i < 100);
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            choice = $urandom_range(0, 19);
            if (choice == 0) begin
               walk_ord = walk_ord + 2'd2;
            end else if (choice > 2) begin
               if ($urandom_range(0, 15) == 0) walk_dir = -walk_dir;
               walk_ord = walk_ord + walk_dir;
            end
            stamp = ($urandom_range(0, 30) == 0) ? $urandom : stamp + $urandom_range(0, 40);
            send_sample(ordinal_phase(walk_ord), stamp);
         end else if (pick < 82) begin
            w = rand_word(qpt_pkg::KIND_SET);
            if ($urandom_range(0, 1) == 1) w.new_position = 32'h7FFF_FFF8 + $urandom_range(0, 15);
            send_word(w);
         end else begin
            send_word(rand_word(3'(qpt_pkg::KIND_READ_CLEAR + $urandom_range(0, 2))));
         end
      end
      no_gaps = 1'b0;
      rsp_quiet = 1'b0;
      drain_reports();
   endtask

   task automatic test_backpressure_fill();
      logic [1:0] walk_ord;
      walk_ord = phase_ordinal(trk_phase);
      hold_cycles = 200;
      no_gaps = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 5 == 4) begin
            send_word(rand_word(3'(qpt_pkg::KIND_READ_CLEAR + $urandom_range(0, 2))));
         end else begin
            walk_ord = walk_ord + 2'd1;
            send_sample(ordinal_phase(walk_ord), $urandom);
         end
      end
      no_gaps = 1'b0;
      drain_reports();
   endtask

   task automatic test_random_mix(input int unsigned count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 0) send_word(rand_word(qpt_pkg::KIND_SAMPLE));
         else send_word(rand_word(3'($urandom_range(1, 7))));
      end
      drain_reports();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_phase_steps();
      test_position_wrap();
      test_read_kinds();
      test_unused_kinds();
      test_random_rotation(400);
      test_backpressure_fill();
      test_random_mix(300);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### quadrature_position_tracker_core.f
+incdir+hw/rtl
hw/rtl/qpt_pkg.sv
hw/rtl/qpt_update.sv
hw/rtl/quadrature_position_tracker_core.sv
dv/tb_quadrature_position_tracker_core.sv
